FILE: rtl/core/brush_tire_friction_assert.svh
// ---------------------------------------------------------------------------
// Brush tire friction assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ---------------------------------------------------------------------------
`ifndef BRUSH_TIRE_FRICTION_ASSERT_SVH
`define BRUSH_TIRE_FRICTION_ASSERT_SVH

// same-cycle implication
`define BTF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BTF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/btf_pkg.sv
// ---------------------------------------------------------------------------
// Brush tire friction package
// Fixed-point constants and register indexes shared by the block.
// ---------------------------------------------------------------------------
`default_nettype none

package btf_pkg;

  localparam int SPEED_W    = 32;
  localparam int FRIC_W     = 20;
  localparam int STIFF_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int FRAC_W     = 16;
  localparam int WSLIP_W    = 31;

  localparam logic [CFG_IDX_W-1:0] REG_LAT_STIFF  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_STIFF = 2'd1;

  localparam logic [STIFF_W-1:0] STIFF_RESET    = 32'd65536;
  localparam logic [SPEED_W-1:0] MIN_TIRE_SPEED = 32'd6554;   // 0.1
  localparam logic [SPEED_W-1:0] LAT_SLIP_BIAS  = 32'd655;    // 0.01
  localparam logic [SPEED_W-1:0] GAMMA_BIAS     = 32'd66;     // 0.001
  localparam logic [FRIC_W-1:0]  FRICTION_MAX   = 20'd655360; // 10.0
  localparam logic [32:0]        ONE_Q16        = 33'd65536;

  // restoring divider depths and root width, one quotient or root bit per stage
  localparam int SLIP_QW = 48;
  localparam int NORM_QW = 32;
  localparam int FRIC_QW = 20;
  localparam int ROOT_W  = 32;

endpackage

`default_nettype wire

FILE: rtl/core/brush_tire_friction.sv
// ---------------------------------------------------------------------------
// Brush tire friction
// Combined-slip brush tire model: contact speeds and surface friction in,
// lateral and longitudinal friction coefficients out, all Q16.16.
// ---------------------------------------------------------------------------
//   port group | direction | handshake      | word
//   in_*       | input     | valid / ready  | three speeds + surface friction
//   out_*      | output    | valid / ready  | lateral + longitudinal friction
//   cfg_*      | input     | write enable   | stiffness register write
//
// One word enters per cycle while no output word is held. The pipeline
// chains bit-per-stage units: 48-stage slip divide, 32-stage normalize
// divide, 32-stage root and 20-stage friction divide, plus 9 plain stages.
// rst_n (synchronous) clears all valid bits and sets both stiffnesses to 1.0.
// A held output word freezes the pipeline; the input register still takes
// one word while it is empty.
// ---------------------------------------------------------------------------
`default_nettype none

module brush_tire_friction (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [btf_pkg::SPEED_W-1:0]     in_long_rel_speed,
  input  wire logic [btf_pkg::SPEED_W-1:0]     in_side_rel_speed,
  input  wire logic [btf_pkg::SPEED_W-1:0]     in_tire_long_speed,
  input  wire logic [btf_pkg::FRIC_W-1:0]      in_surface_friction,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [btf_pkg::FRIC_W-1:0]      out_lateral_friction,
  output logic      [btf_pkg::FRIC_W-1:0]      out_longitudinal_friction,
  input  wire logic                            cfg_we,
  input  wire logic [btf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [btf_pkg::STIFF_W-1:0]     cfg_wdata
);

  import btf_pkg::*;

  `include "brush_tire_friction_assert.svh"

  // ---- stiffness registers ----
  logic [STIFF_W-1:0] lat_stiff_r;
  logic [STIFF_W-1:0] long_stiff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_stiff_r  <= STIFF_RESET;
      long_stiff_r <= STIFF_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LAT_STIFF:  lat_stiff_r  <= cfg_wdata;
        REG_LONG_STIFF: long_stiff_r <= cfg_wdata;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // ---- global advance: everything moves unless the output word is held ----
  logic en;
  logic out_valid_r;
  assign en       = !out_valid_r || out_ready;

  // ---- S0: input capture; may fill while the rest is frozen ----
  logic               v0_r;
  logic [SPEED_W-1:0] rel_raw_r, side_raw_r, tire_raw_r;
  logic [FRIC_W-1:0]  fric_raw_r;

  assign in_ready = en || !v0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (in_ready) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      rel_raw_r  <= in_long_rel_speed;
      side_raw_r <= in_side_rel_speed;
      tire_raw_r <= in_tire_long_speed;
      fric_raw_r <= in_surface_friction;
    end
  end

  // ---- S1: magnitudes, tire speed floor, slip bias, friction clamp ----
  // two's-complement magnitude; the most negative code gives 2^31 exactly
  logic [SPEED_W-1:0] rel_mag, side_mag, tire_mag, tire_nxt;
  logic [FRIC_W-1:0]  fric_nxt;

  assign rel_mag  = rel_raw_r[SPEED_W-1]  ? (~rel_raw_r + 1'b1)  : rel_raw_r;
  assign side_mag = side_raw_r[SPEED_W-1] ? (~side_raw_r + 1'b1) : side_raw_r;
  assign tire_mag = tire_raw_r[SPEED_W-1] ? (~tire_raw_r + 1'b1) : tire_raw_r;
  assign tire_nxt = (tire_mag < MIN_TIRE_SPEED) ? MIN_TIRE_SPEED : tire_mag;
  assign fric_nxt = (fric_raw_r > FRICTION_MAX) ? FRICTION_MAX : fric_raw_r;

  logic               v1_r;
  logic [SPEED_W-1:0] rel1_r, side1_r, tire1_r, lden1_r;
  logic [FRIC_W-1:0]  fric1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rel1_r  <= rel_mag;
      side1_r <= side_mag;
      tire1_r <= tire_nxt;
      lden1_r <= rel_mag + LAT_SLIP_BIAS;   // max 2^31 + 655, no carry out
      fric1_r <= fric_nxt;
    end
  end

  // ---- slip divides: rel/ts and side/(rel+0.01), Q16.16 quotients ----
  logic               ls_valid, lat_valid;
  logic [SLIP_QW-1:0] ls_quot, lat_quot;
  logic [FRIC_W-1:0]  fric_a;

  btf_div #(.DW(SPEED_W), .QW(SLIP_QW)) u_div_long_slip (
    .clk, .rst_n, .en,
    .in_valid (v1_r),
    .in_rem   ('0),
    .in_num   ({rel1_r, 16'h0000}),
    .in_den   (tire1_r),
    .out_valid(ls_valid),
    .out_quot (ls_quot)
  );

  btf_div #(.DW(SPEED_W), .QW(SLIP_QW)) u_div_lat_slip (
    .clk, .rst_n, .en,
    .in_valid (v1_r),
    .in_rem   ('0),
    .in_num   ({side1_r, 16'h0000}),
    .in_den   (lden1_r),
    .out_valid(lat_valid),
    .out_quot (lat_quot)
  );

  btf_delay #(.W(FRIC_W), .DEPTH(SLIP_QW)) u_dly_fric_slip (
    .clk, .en,
    .in_data (fric1_r),
    .out_data(fric_a)
  );

  // ---- S2: slip saturation, 1 + longitudinal slip ----
  logic [SPEED_W-1:0] ls_sat, lat_sat;
  assign ls_sat  = (|ls_quot[SLIP_QW-1:SPEED_W])  ? '1 : ls_quot[SPEED_W-1:0];
  assign lat_sat = (|lat_quot[SLIP_QW-1:SPEED_W]) ? '1 : lat_quot[SPEED_W-1:0];

  logic               v2_r;
  logic [SPEED_W-1:0] ls2_r, lat2_r;
  logic [SPEED_W:0]   onep2_r;
  logic [FRIC_W-1:0]  fric2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= ls_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ls2_r   <= ls_sat;
      lat2_r  <= lat_sat;
      onep2_r <= {1'b0, ls_sat} + ONE_Q16;
      fric2_r <= fric_a;
    end
  end

  // ---- normalize: u = ls/(1+ls), v = lat/(1+ls) ----
  // upper 16 bits of each dividend start as remainder (already below 1+ls)
  logic               u_valid, nv_valid;
  logic [NORM_QW-1:0] u_quot, nv_quot;
  logic [FRIC_W-1:0]  fric_c;

  btf_div #(.DW(SPEED_W+1), .QW(NORM_QW)) u_div_norm_long (
    .clk, .rst_n, .en,
    .in_valid (v2_r),
    .in_rem   ({17'h0, ls2_r[31:16]}),
    .in_num   ({ls2_r[15:0], 16'h0000}),
    .in_den   (onep2_r),
    .out_valid(u_valid),
    .out_quot (u_quot)
  );

  btf_div #(.DW(SPEED_W+1), .QW(NORM_QW)) u_div_norm_lat (
    .clk, .rst_n, .en,
    .in_valid (v2_r),
    .in_rem   ({17'h0, lat2_r[31:16]}),
    .in_num   ({lat2_r[15:0], 16'h0000}),
    .in_den   (onep2_r),
    .out_valid(nv_valid),
    .out_quot (nv_quot)
  );

  btf_delay #(.W(FRIC_W), .DEPTH(NORM_QW)) u_dly_fric_norm (
    .clk, .en,
    .in_data (fric2_r),
    .out_data(fric_c)
  );

  // ---- M1..M4: stiffness weighting, saturation, squares, sum ----
  logic                 vm1_r, vm2_r, vm3_r, vm4_r;
  logic [63:0]          pz_r, px_r;
  logic [WSLIP_W-1:0]   cz2_r, cx2_r, cz3_r, cx3_r, cz4_r, cx4_r;
  logic [2*WSLIP_W-1:0] sz_r, sx_r;
  logic [63:0]          rad_r;
  logic [FRIC_W-1:0]    fm1_r, fm2_r, fm3_r, fm4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm1_r <= 1'b0;
      vm2_r <= 1'b0;
      vm3_r <= 1'b0;
      vm4_r <= 1'b0;
    end else if (en) begin
      vm1_r <= u_valid;
      vm2_r <= vm1_r;
      vm3_r <= vm2_r;
      vm4_r <= vm3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pz_r  <= lat_stiff_r * nv_quot;
      px_r  <= long_stiff_r * u_quot;
      fm1_r <= fric_c;
      // (p >> 16) clamps at 0x7FFFFFFF
      cz2_r <= (|pz_r[63:47]) ? '1 : pz_r[46:16];
      cx2_r <= (|px_r[63:47]) ? '1 : px_r[46:16];
      fm2_r <= fm1_r;
      sz_r  <= cz2_r * cz2_r;
      sx_r  <= cx2_r * cx2_r;
      cz3_r <= cz2_r;
      cx3_r <= cx2_r;
      fm3_r <= fm2_r;
      rad_r <= {1'b0, {1'b0, sz_r} + {1'b0, sx_r}};
      cz4_r <= cz3_r;
      cx4_r <= cx3_r;
      fm4_r <= fm3_r;
    end
  end

  // ---- magnitude root ----
  logic                         root_valid;
  logic [ROOT_W-1:0]            root;
  logic [FRIC_W+2*WSLIP_W-1:0]  side_g;

  btf_sqrt #(.RW(ROOT_W)) u_sqrt (
    .clk, .rst_n, .en,
    .in_valid (vm4_r),
    .in_rad   (rad_r),
    .out_valid(root_valid),
    .out_root (root)
  );

  btf_delay #(.W(FRIC_W+2*WSLIP_W), .DEPTH(ROOT_W)) u_dly_root (
    .clk, .en,
    .in_data ({fm4_r, cz4_r, cx4_r}),
    .out_data(side_g)
  );

  // ---- G: gamma and friction products ----
  logic                      vg_r;
  logic [ROOT_W-1:0]         gamma_r;
  logic [FRIC_W+WSLIP_W-1:0] fz_r, fx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vg_r <= 1'b0;
    end else if (en) begin
      vg_r <= root_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gamma_r <= root + GAMMA_BIAS;  // root below 2^31.6, no wrap
      fz_r    <= side_g[FRIC_W+2*WSLIP_W-1:2*WSLIP_W] * side_g[2*WSLIP_W-1:WSLIP_W];
      fx_r    <= side_g[FRIC_W+2*WSLIP_W-1:2*WSLIP_W] * side_g[WSLIP_W-1:0];
    end
  end

  // ---- friction split: f*c/gamma, quotient <= f so 20 bits suffice ----
  logic              lf_valid, xf_valid;
  logic [FRIC_W-1:0] lf_quot, xf_quot;

  btf_div #(.DW(ROOT_W), .QW(FRIC_QW)) u_div_fric_lat (
    .clk, .rst_n, .en,
    .in_valid (vg_r),
    .in_rem   ({1'b0, fz_r[FRIC_W+WSLIP_W-1:FRIC_W]}),
    .in_num   (fz_r[FRIC_W-1:0]),
    .in_den   (gamma_r),
    .out_valid(lf_valid),
    .out_quot (lf_quot)
  );

  btf_div #(.DW(ROOT_W), .QW(FRIC_QW)) u_div_fric_long (
    .clk, .rst_n, .en,
    .in_valid (vg_r),
    .in_rem   ({1'b0, fx_r[FRIC_W+WSLIP_W-1:FRIC_W]}),
    .in_num   (fx_r[FRIC_W-1:0]),
    .in_den   (gamma_r),
    .out_valid(xf_valid),
    .out_quot (xf_quot)
  );

  // ---- output register ----
  logic [FRIC_W-1:0] lat_fric_r, long_fric_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= lf_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lat_fric_r  <= lf_quot;
      long_fric_r <= xf_quot;
    end
  end

  assign out_valid                 = out_valid_r;
  assign out_lateral_friction      = lat_fric_r;
  assign out_longitudinal_friction = long_fric_r;

  // ---- assertions ----
  `BTF_ASSERT_NOW(a_slip_align, ls_valid || lat_valid, ls_valid && lat_valid, "slip dividers out of step")
  `BTF_ASSERT_NOW(a_norm_align, u_valid || nv_valid, u_valid && nv_valid, "normalize dividers out of step")
  `BTF_ASSERT_NOW(a_fric_align, lf_valid || xf_valid, lf_valid && xf_valid, "friction dividers out of step")
  `BTF_ASSERT_NOW(a_fric_range, out_valid_r, (lat_fric_r <= FRICTION_MAX) && (long_fric_r <= FRICTION_MAX), "friction above surface limit")
  `BTF_ASSERT_NOW(a_stall_cause, !in_ready, out_valid_r && !out_ready && v0_r, "input stalled without a held output")

endmodule

`default_nettype wire

FILE: rtl/core/btf_delay.sv
// ---------------------------------------------------------------------------
// Brush tire friction delay line
// Stall-aware shift line that keeps side data aligned with a long unit.
// ---------------------------------------------------------------------------
`default_nettype none

module btf_delay #(
  parameter int W     = 20,
  parameter int DEPTH = 32
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [W-1:0] in_data,
  output logic      [W-1:0] out_data
);

  logic [W-1:0] tap_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= in_data;
      for (int i = 1; i < DEPTH; i++) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  assign out_data = tap_r[DEPTH-1];

endmodule

`default_nettype wire

FILE: rtl/core/btf_div.sv
// ---------------------------------------------------------------------------
// Brush tire friction pipelined divider
// Restoring divide, one quotient bit per register stage.
// The starting remainder must be below the divisor.
// ---------------------------------------------------------------------------
`default_nettype none

module btf_div #(
  parameter int DW = 32,
  parameter int QW = 48
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [DW-1:0] in_rem,
  input  wire logic [QW-1:0] in_num,
  input  wire logic [DW-1:0] in_den,
  output logic               out_valid,
  output logic      [QW-1:0] out_quot
);

  logic          v_r    [QW];
  logic [DW-1:0] rem_r  [QW];
  logic [QW-1:0] num_r  [QW];
  logic [DW-1:0] den_r  [QW];
  logic [QW-1:0] quot_r [QW];

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic          v_p;
    logic [DW-1:0] rem_p;
    logic [QW-1:0] num_p;
    logic [DW-1:0] den_p;
    logic [QW-1:0] quot_p;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          take;

    if (i == 0) begin : g_first
      assign v_p    = in_valid;
      assign rem_p  = in_rem;
      assign num_p  = in_num;
      assign den_p  = in_den;
      assign quot_p = '0;
    end else begin : g_next
      assign v_p    = v_r[i-1];
      assign rem_p  = rem_r[i-1];
      assign num_p  = num_r[i-1];
      assign den_p  = den_r[i-1];
      assign quot_p = quot_r[i-1];
    end

    assign trial = {rem_p, num_p[QW-1]};
    assign take  = trial >= {1'b0, den_p};
    assign diff  = trial - {1'b0, den_p};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= take ? diff[DW-1:0] : trial[DW-1:0];
        num_r[i]  <= {num_p[QW-2:0], 1'b0};
        den_r[i]  <= den_p;
        quot_r[i] <= {quot_p[QW-2:0], take};
      end
    end
  end

  assign out_valid = v_r[QW-1];
  assign out_quot  = quot_r[QW-1];

endmodule

`default_nettype wire

FILE: rtl/core/btf_sqrt.sv
// ---------------------------------------------------------------------------
// Brush tire friction pipelined square root
// Digit-by-digit integer root, one result bit per register stage.
// ---------------------------------------------------------------------------
`default_nettype none

module btf_sqrt #(
  parameter int RW = 32
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire logic [2*RW-1:0] in_rad,
  output logic                 out_valid,
  output logic      [RW-1:0]   out_root
);

  logic            v_r    [RW];
  logic [RW+1:0]   rem_r  [RW];
  logic [RW-1:0]   root_r [RW];
  logic [2*RW-1:0] rad_r  [RW];

  for (genvar i = 0; i < RW; i++) begin : g_step
    logic            v_p;
    logic [RW+1:0]   rem_p;
    logic [RW-1:0]   root_p;
    logic [2*RW-1:0] rad_p;
    logic [RW+1:0]   cur;
    logic [RW+1:0]   trial;
    logic            take;

    if (i == 0) begin : g_first
      assign v_p    = in_valid;
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = in_rad;
    end else begin : g_next
      assign v_p    = v_r[i-1];
      assign rem_p  = rem_r[i-1];
      assign root_p = root_r[i-1];
      assign rad_p  = rad_r[i-1];
    end

    // remainder stays below 2^RW before each step
    assign cur   = {rem_p[RW-1:0], rad_p[2*RW-1:2*RW-2]};
    assign trial = {root_p, 2'b01};
    assign take  = cur >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= take ? (cur - trial) : cur;
        root_r[i] <= {root_p[RW-2:0], take};
        rad_r[i]  <= {rad_p[2*RW-3:0], 2'b00};
      end
    end
  end

  assign out_valid = v_r[RW-1];
  assign out_root  = root_r[RW-1];

endmodule

`default_nettype wire

FILE: tb/sv/brush_tire_friction_test.sv
// ---------------------------------------------------------------------------
// Brush tire friction testbench
// Drives contact words through the friction pipeline under random burst and
// stall patterns. Checks each result word against a bit-exact fixed-point
// predictor. A directed table comes first, then random words, over several
// stiffness settings.
// ---------------------------------------------------------------------------
`default_nettype none

module brush_tire_friction_test;
  timeunit 1ns;
  timeprecision 1ps;
  import btf_pkg::*;

  localparam int LATENCY   = 141;
  localparam int STALL_MAX = 20000;
  localparam int N_RANDOM  = 1620;
  localparam int N_PHASES  = 5;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [SPEED_W-1:0] in_long_rel_speed = '0;
  logic [SPEED_W-1:0] in_side_rel_speed = '0;
  logic [SPEED_W-1:0] in_tire_long_speed = '0;
  logic [FRIC_W-1:0] in_surface_friction = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [FRIC_W-1:0] out_lateral_friction;
  logic [FRIC_W-1:0] out_longitudinal_friction;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [STIFF_W-1:0] cfg_wdata = '0;

  brush_tire_friction i_dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  typedef struct packed {
    logic [SPEED_W-1:0] long_rel;
    logic [SPEED_W-1:0] side_rel;
    logic [SPEED_W-1:0] tire_long;
    logic [FRIC_W-1:0]  mu;
  } contact_t;

  typedef struct packed {
    logic [FRIC_W-1:0] lat;
    logic [FRIC_W-1:0] lon;
  } friction_t;

  // Predictor copy of the stiffness registers.
  logic [STIFF_W-1:0] lat_stiff_q;
  logic [STIFF_W-1:0] long_stiff_q;

  friction_t pending_friction[$];
  int        mismatches = 0;
  int        idle_cycles = 0;

  function automatic logic [63:0] speed_mag(logic [31:0] raw);
    return raw[31] ? 64'(33'h1_0000_0000 - 33'(raw)) : 64'(raw);
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] n);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Brush tire combined slip, fixed point; 128-bit intermediates avoid wrap.
  function automatic friction_t brush_friction(contact_t c);
    logic [127:0] rel, side, ts, mu, ls, lat, onep, u, v, cz, cx, gam;
    friction_t r;
    rel  = 128'(speed_mag(c.long_rel));
    side = 128'(speed_mag(c.side_rel));
    ts   = 128'(speed_mag(c.tire_long));
    mu   = (c.mu > FRICTION_MAX) ? 128'(FRICTION_MAX) : 128'(c.mu);
    if (ts < 128'(MIN_TIRE_SPEED)) ts = 128'(MIN_TIRE_SPEED);
    ls = (rel << 16) / ts;
    if (ls > 128'hFFFF_FFFF) ls = 128'hFFFF_FFFF;
    lat = (side << 16) / (rel + 128'(LAT_SLIP_BIAS));
    if (lat > 128'hFFFF_FFFF) lat = 128'hFFFF_FFFF;
    onep = 128'(ONE_Q16) + ls;
    u = (ls << 16) / onep;
    v = (lat << 16) / onep;
    cz = (128'(lat_stiff_q) * v) >> 16;
    cx = (128'(long_stiff_q) * u) >> 16;
    if (cz > 128'h7FFF_FFFF) cz = 128'h7FFF_FFFF;
    if (cx > 128'h7FFF_FFFF) cx = 128'h7FFF_FFFF;
    gam = 128'(root_floor(64'(cx * cx + cz * cz))) + 128'(GAMMA_BIAS);
    r.lat = FRIC_W'((mu * cz) / gam);
    r.lon = FRIC_W'((mu * cx) / gam);
    return r;
  endfunction

  task automatic report_mismatch(string line);
    $display("MISMATCH %s at %0t", line, $realtime);
    mismatches++;
  endtask

  // Directed table; a row with has_want set carries a hand-read result,
  // which is checked against the predictor output.
  typedef struct {
    contact_t  c;
    bit        has_want;
    friction_t want;
  } row_t;

  row_t directed[$];

  task automatic add_row(logic [31:0] a, logic [31:0] s, logic [31:0] t,
                         logic [19:0] m, bit hw = 0, logic [19:0] wl = 0,
                         logic [19:0] wx = 0);
    row_t r;
    r.c = '{a, s, t, m};
    r.has_want = hw;
    r.want = '{wl, wx};
    directed.push_back(r);
  endtask

  // Configuration write, block idle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [STIFF_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_LAT_STIFF) lat_stiff_q = val;
    else if (idx == REG_LONG_STIFF) long_stiff_q = val;
  endtask

  // Sender: bursts of random length with random gaps, inputs change at negedge.
  int burst_left = 0;

  task automatic send_word(contact_t c);
    while (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(50, 200);  // stretch with no gaps
      end else begin
        repeat ($urandom_range(0, 4)) @(negedge clk);
        burst_left = $urandom_range(1, 12);
      end
    end
    burst_left--;
    in_valid = 1'b1;
    in_long_rel_speed = c.long_rel;
    in_side_rel_speed = c.side_rel;
    in_tire_long_speed = c.tire_long;
    in_surface_friction = c.mu;
    do @(posedge clk); while (!in_ready);
    pending_friction.push_back(brush_friction(c));
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain;
    while (pending_friction.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_speed();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 20000)) - 10000);
      2: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
      3: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  function automatic contact_t rand_contact();
    contact_t c;
    c.long_rel  = rand_speed();
    c.side_rel  = rand_speed();
    c.tire_long = rand_speed();
    c.mu = ($urandom_range(0, 7) == 0) ? 20'($urandom()) : 20'($urandom_range(0, 655360));
    return c;
  endfunction

  // Receiver stall pattern: its own period and duty, with stall-free stretches.
  initial begin
    int mode;
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(20, 150)) begin
        @(negedge clk);
        case (mode)
          0: out_ready = 1'b1;
          1: out_ready = ($urandom_range(0, 3) != 0);
          2: out_ready = ($urandom_range(0, 3) == 0);
          default: out_ready = ~out_ready;
        endcase
      end
    end
  end

  // Result checker, sampled at the rising edge.
  always @(posedge clk) begin
    friction_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_friction.size() == 0) begin
        report_mismatch("unexpected result word");
      end else begin
        want = pending_friction.pop_front();
        if (out_lateral_friction !== want.lat)
          report_mismatch($sformatf("lateral_friction: got %0d want %0d",
                                    out_lateral_friction, want.lat));
        if (out_longitudinal_friction !== want.lon)
          report_mismatch($sformatf("longitudinal_friction: got %0d want %0d",
                                    out_longitudinal_friction, want.lon));
      end
    end
  end

  // Watchdog: cycles with no word accepted on either side.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_MAX) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    logic [STIFF_W-1:0] lat_set[N_PHASES];
    logic [STIFF_W-1:0] long_set[N_PHASES];
    friction_t got;
    lat_stiff_q = STIFF_RESET;
    long_stiff_q = STIFF_RESET;
    lat_set  = '{32'd65536, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'd200000};
    long_set = '{32'd65536, 32'd0, 32'hFFFF_FFFF, 32'd3000000, 32'd1};

    // zero slip or zero friction gives zero outputs
    add_row(32'd0, 32'd0, 32'd0, 20'd0, 1, 20'd0, 20'd0);
    add_row(32'd0, 32'd0, 32'd655360, 20'd655360, 1, 20'd0, 20'd0);
    add_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 20'd0, 1, 20'd0, 20'd0);
    add_row(32'd65536, 32'd0, 32'd65536, 20'd65536);
    add_row(32'd0, 32'd65536, 32'd65536, 20'd65536);
    // slow tire, floored at 0.1
    add_row(32'd65536, 32'd32768, 32'd1, 20'd65536);
    add_row(32'd65536, 32'd32768, 32'hFFFF_FFFF, 20'd65536);
    // most negative speed
    add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 20'd655360);
    add_row(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 20'd655360);
    // slip overflow
    add_row(32'h7FFF_FFFF, 32'd0, 32'd0, 20'd655360);
    add_row(32'd0, 32'h8000_0000, 32'd6554, 20'd655360);
    // friction above ten saturates, then alternating bit patterns
    add_row(32'd65536, 32'd65536, 32'd131072, 20'hFFFFF);
    add_row(32'hFFFF_0000, 32'h0001_0000, 32'h0002_0000, 20'd655361);
    add_row(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 20'hAAAAA);
    add_row(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 20'h55555);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[k]) begin
      if (directed[k].has_want) begin
        got = brush_friction(directed[k].c);
        if (got !== directed[k].want)
          report_mismatch($sformatf("directed row %0d predictor", k));
      end
      send_word(directed[k].c);
    end
    drain();

    // register index beyond one is ignored
    write_reg(2'd2, 32'd12345);
    write_reg(2'd3, 32'd0);

    for (int p = 0; p < N_PHASES; p++) begin
      write_reg(REG_LAT_STIFF, lat_set[p]);
      write_reg(REG_LONG_STIFF, long_set[p]);
      repeat (N_RANDOM / N_PHASES) send_word(rand_contact());
      drain();
    end

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
